// ===== design/sparse_set_component_pool_unit_assert.svh =====
// Assertion macros for the sparse set component pool.
`ifndef SPARSE_SET_COMPONENT_POOL_UNIT_ASSERT_SVH
`define SPARSE_SET_COMPONENT_POOL_UNIT_ASSERT_SVH

// Check a property on every rising clock edge outside reset.
`define SSPOOL_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Check an implication on every rising clock edge outside reset.
`define SSPOOL_ASSERT_IMPL(label, cond, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (prop)) \
      else $error(msg);

`endif

// ===== design/sspool_pkg.sv =====
package sspool_pkg;

   localparam int ENTITY_SLOTS = 1024;
   localparam int POOL_DEPTH   = 1024;
   localparam int DATA_WIDTH   = 32;

   localparam int ENTITY_BITS = 16;
   localparam int ENT_BITS    = $clog2(ENTITY_SLOTS);
   localparam int SLOT_BITS   = $clog2(POOL_DEPTH);
   localparam int LINK_BITS   = $clog2(POOL_DEPTH + 1);
   localparam int COUNT_BITS  = LINK_BITS;
   localparam int DENSE_BITS  = ENTITY_BITS + DATA_WIDTH;

   localparam logic [1:0] CMD_LOOKUP = 2'd0;
   localparam logic [1:0] CMD_INSERT = 2'd1;
   localparam logic [1:0] CMD_DELETE = 2'd2;

   localparam logic [1:0] ST_OK     = 2'd0;
   localparam logic [1:0] ST_ABSENT = 2'd1;
   localparam logic [1:0] ST_FULL   = 2'd2;
   localparam logic [1:0] ST_RANGE  = 2'd3;

   typedef struct packed {
      logic [1:0]             command;
      logic [ENTITY_BITS-1:0] entity;
      logic [DATA_WIDTH-1:0]  data_in;
      logic                   has_data;
   } req_type;

   typedef struct packed {
      logic [1:0]            status;
      logic [DATA_WIDTH-1:0] data_out;
      logic [SLOT_BITS-1:0]  slot;
      logic [COUNT_BITS-1:0] entry_count;
   } rsp_type;

   typedef struct packed {
      logic                 we;
      logic [ENT_BITS-1:0]  addr;
      logic [LINK_BITS-1:0] wdata;
   } sparse_req_type;

   typedef struct packed {
      logic                  we;
      logic [SLOT_BITS-1:0]  addr;
      logic [DENSE_BITS-1:0] wdata;
   } dense_req_type;

endpackage

// ===== design/sspool_ram.sv =====
module sspool_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== design/sspool_seq.sv =====
module sspool_seq (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  sspool_pkg::req_type                 req,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output sspool_pkg::rsp_type                 rsp,
   output sspool_pkg::sparse_req_type          sparse_req,
   input  logic [sspool_pkg::LINK_BITS-1:0]    sparse_rdata,
   output sspool_pkg::dense_req_type           dense_req,
   input  logic [sspool_pkg::DENSE_BITS-1:0]   dense_rdata
);

   import sspool_pkg::*;

   localparam logic [2:0] S_CLEAR  = 3'd0;
   localparam logic [2:0] S_IDLE   = 3'd1;
   localparam logic [2:0] S_LINK   = 3'd2;
   localparam logic [2:0] S_DENSE  = 3'd3;
   localparam logic [2:0] S_UNLINK = 3'd4;
   localparam logic [2:0] S_HOLD   = 3'd5;

   logic [2:0]            state_ff, state_in;
   logic [ENT_BITS-1:0]   clr_ff, clr_in;
   req_type               req_ff, req_in;
   logic [COUNT_BITS-1:0] fill_ff, fill_in;
   logic                  found_ff, found_in;
   logic [SLOT_BITS-1:0]  idx_ff, idx_in;
   rsp_type               res_ff, res_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_ff, rsp_in;

   logic                  in_range;
   logic                  out_free;
   logic [SLOT_BITS-1:0]  last_slot;
   logic [ENTITY_BITS-1:0] moved;
   logic [DATA_WIDTH-1:0] stored;
   logic                  moved_in_range;

   assign in_range       = {1'b0, req_ff.entity} < (ENTITY_BITS+1)'(ENTITY_SLOTS);
   assign out_free       = !rsp_valid_ff || rsp_ready;
   assign last_slot      = SLOT_BITS'(fill_ff - COUNT_BITS'(1));
   assign moved          = dense_rdata[DENSE_BITS-1:DATA_WIDTH];
   assign stored         = dense_rdata[DATA_WIDTH-1:0];
   assign moved_in_range = {1'b0, moved} < (ENTITY_BITS+1)'(ENTITY_SLOTS);

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      req_in       = req_ff;
      fill_in      = fill_ff;
      found_in     = found_ff;
      idx_in       = idx_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      sparse_req   = '{we: 1'b0, addr: req.entity[ENT_BITS-1:0], wdata: '0};
      dense_req    = '{we: 1'b0, addr: '0, wdata: '0};

      unique case (state_ff)
         S_CLEAR: begin
            sparse_req = '{we: 1'b1, addr: clr_ff, wdata: '0};
            clr_in     = clr_ff + ENT_BITS'(1);
            if (clr_ff == ENT_BITS'(ENTITY_SLOTS - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               req_in   = req;
               state_in = S_LINK;
            end
         end
         S_LINK: begin
            found_in = in_range && (sparse_rdata != '0) && (sparse_rdata <= fill_ff);
            idx_in   = SLOT_BITS'(sparse_rdata - LINK_BITS'(1));
            dense_req.addr = (req_ff.command == CMD_DELETE) ? last_slot : idx_in;
            state_in = S_DENSE;
         end
         S_DENSE: begin
            res_in = '{status: ST_ABSENT, data_out: '0, slot: '0, entry_count: '0};
            state_in = S_IDLE;
            unique case (req_ff.command)
               CMD_INSERT: begin
                  if (found_ff) begin
                     res_in = '{status: ST_OK, data_out: stored, slot: idx_ff,
                                entry_count: '0};
                     if (req_ff.has_data) begin
                        dense_req = '{we: 1'b1, addr: idx_ff,
                                      wdata: {req_ff.entity, req_ff.data_in}};
                        res_in.data_out = req_ff.data_in;
                     end
                  end else if (fill_ff == COUNT_BITS'(POOL_DEPTH)) begin
                     res_in.status = ST_FULL;
                  end else if (!in_range) begin
                     res_in.status = ST_RANGE;
                  end else begin
                     res_in = '{status: ST_OK,
                                data_out: req_ff.has_data ? req_ff.data_in : '0,
                                slot: SLOT_BITS'(fill_ff), entry_count: '0};
                     dense_req  = '{we: 1'b1, addr: SLOT_BITS'(fill_ff),
                                    wdata: {req_ff.entity, res_in.data_out}};
                     sparse_req = '{we: 1'b1, addr: req_ff.entity[ENT_BITS-1:0],
                                    wdata: LINK_BITS'(fill_ff + COUNT_BITS'(1))};
                     fill_in    = fill_ff + COUNT_BITS'(1);
                  end
               end
               CMD_DELETE: begin
                  if (found_ff) begin
                     res_in = '{status: ST_OK, data_out: '0, slot: idx_ff,
                                entry_count: '0};
                     fill_in = fill_ff - COUNT_BITS'(1);
                     if (idx_ff != last_slot) begin
                        dense_req = '{we: 1'b1, addr: idx_ff, wdata: dense_rdata};
                        sparse_req = '{we: moved_in_range, addr: moved[ENT_BITS-1:0],
                                       wdata: LINK_BITS'({1'b0, idx_ff} + 1'b1)};
                        state_in = S_UNLINK;
                     end else begin
                        sparse_req = '{we: 1'b1, addr: req_ff.entity[ENT_BITS-1:0],
                                       wdata: '0};
                     end
                  end
               end
               default: begin
                  if (found_ff) begin
                     res_in = '{status: ST_OK, data_out: stored, slot: idx_ff,
                                entry_count: '0};
                  end
               end
            endcase
            if (state_in == S_IDLE) begin
               if (out_free) begin
                  rsp_valid_in = 1'b1;
                  rsp_in       = res_in;
                  rsp_in.entry_count = fill_in;
               end else begin
                  state_in = S_HOLD;
               end
            end
         end
         S_UNLINK: begin
            sparse_req = '{we: 1'b1, addr: req_ff.entity[ENT_BITS-1:0], wdata: '0};
            state_in   = S_HOLD;
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_in       = res_ff;
               rsp_in.entry_count = fill_ff;
               state_in     = S_IDLE;
            end
         end
         S_HOLD: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_in       = res_ff;
               rsp_in.entry_count = fill_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      req_ff   <= req_in;
      found_ff <= found_in;
      idx_ff   <= idx_in;
      res_ff   <= res_in;
      rsp_ff   <= rsp_in;
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

// ===== design/sparse_set_component_pool_unit.sv =====
// Sequence: an accepted request passes the LINK and DENSE states before its response
//   is registered; a delete that moves the last entry into the freed slot adds UNLINK
//   (extra sparse table write). A new request is accepted only back in idle, set by the
//   read-modify-write sequence over the single-port sparse and dense memories.
// Reset: fill count cleared, then a pass over every sparse entry clears the sparse table
//   with req_tready low; the dense memory is not cleared.
module sparse_set_component_pool_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // entity[15:0], data_in[47:16]
   input  logic [2:0]  req_tuser,   // command[1:0], has_data[2]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,   // data_out[31:0], slot[41:32], entry_count[52:42]
   output logic [1:0]  rsp_tuser    // status[1:0]
);

   import sspool_pkg::*;

   `include "sparse_set_component_pool_unit_assert.svh"

   req_type        req;
   rsp_type        rsp;
   sparse_req_type sparse_req;
   dense_req_type  dense_req;
   logic [LINK_BITS-1:0]  sparse_rdata;
   logic [DENSE_BITS-1:0] dense_rdata;

   assign req.command  = req_tuser[1:0];
   assign req.has_data = req_tuser[2];
   assign req.entity   = req_tdata[15:0];
   assign req.data_in  = req_tdata[47:16];

   sspool_ram #(.WIDTH(LINK_BITS), .DEPTH(ENTITY_SLOTS)) u_sparse (
      .clock (clock),
      .we    (sparse_req.we),
      .addr  (sparse_req.addr),
      .wdata (sparse_req.wdata),
      .rdata (sparse_rdata)
   );

   sspool_ram #(.WIDTH(DENSE_BITS), .DEPTH(POOL_DEPTH)) u_dense (
      .clock (clock),
      .we    (dense_req.we),
      .addr  (dense_req.addr),
      .wdata (dense_req.wdata),
      .rdata (dense_rdata)
   );

   sspool_seq u_seq (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_tvalid),
      .req_ready    (req_tready),
      .req          (req),
      .rsp_valid    (rsp_tvalid),
      .rsp_ready    (rsp_tready),
      .rsp          (rsp),
      .sparse_req   (sparse_req),
      .sparse_rdata (sparse_rdata),
      .dense_req    (dense_req),
      .dense_rdata  (dense_rdata)
   );

   assign rsp_tdata = {3'b000, rsp.entry_count, rsp.slot, rsp.data_out};
   assign rsp_tuser = rsp.status;

   `SSPOOL_ASSERT_IMPL(a_full_count, rsp_tvalid && rsp.status == ST_FULL,
      rsp.entry_count == COUNT_BITS'(POOL_DEPTH), "pool full reported below depth")
   `SSPOOL_ASSERT_IMPL(a_fail_zero, rsp_tvalid && rsp.status != ST_OK,
      rsp.data_out == '0 && rsp.slot == '0, "failed transaction carries payload")
   `SSPOOL_ASSERT_IMPL(a_idle_no_write, req_tready,
      !sparse_req.we && !dense_req.we, "memory write while accepting a transaction")
   `SSPOOL_ASSERT(a_count_bound, rsp.entry_count <= COUNT_BITS'(POOL_DEPTH) || !rsp_tvalid,
      "entry count beyond pool depth")

endmodule

// ===== bench/sparse_set_component_pool_unit_tb.sv =====
module sparse_set_component_pool_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import sspool_pkg::*;

   localparam logic [1:0] CMD_UNUSED = 2'd3;
   localparam int CYCLE_LIMIT = 400000;
   localparam int DRAIN_CYCLES = 16;

   class sparse_pool_model;
      int unsigned link_of [ENTITY_SLOTS];
      int unsigned owner_at [POOL_DEPTH];
      logic [DATA_WIDTH-1:0] value_at [POOL_DEPTH];
      int unsigned fill;
      int unsigned peak_fill;
      rsp_type awaited_replies [$];
      int failures;
      int requests;
      int replies;
      int status_seen [4];

      function new();
         foreach (link_of[i]) link_of[i] = 0;
         foreach (owner_at[i]) owner_at[i] = 0;
         foreach (value_at[i]) value_at[i] = '0;
         foreach (status_seen[i]) status_seen[i] = 0;
         fill = 0;
         peak_fill = 0;
         failures = 0;
         requests = 0;
         replies = 0;
      endfunction

      function bit locate(input int unsigned ent, output int unsigned slot);
         int unsigned link;
         slot = 0;
         if (ent >= ENTITY_SLOTS) return 1'b0;
         link = link_of[ent];
         if (link == 0 || link > fill) return 1'b0;
         slot = link - 1;
         return 1'b1;
      endfunction

      function void apply_request(input logic [1:0] cmd, input logic [ENTITY_BITS-1:0] ent_in,
                                  input logic [DATA_WIDTH-1:0] din, input bit hd);
         rsp_type r;
         int unsigned ent;
         int unsigned idx;
         int unsigned last;
         int unsigned moved;
         r = '0;
         ent = int'(ent_in);
         idx = 0;
         requests++;
         if (cmd == CMD_INSERT) begin
            if (locate(ent, idx)) begin
               if (hd) value_at[idx] = din;
               r.status = ST_OK;
               r.data_out = value_at[idx];
               r.slot = SLOT_BITS'(idx);
            end else if (fill >= POOL_DEPTH) begin
               r.status = ST_FULL;
            end else if (ent >= ENTITY_SLOTS) begin
               r.status = ST_RANGE;
            end else begin
               idx = fill;
               owner_at[idx] = ent;
               value_at[idx] = hd ? din : '0;
               link_of[ent] = idx + 1;
               fill++;
               r.status = ST_OK;
               r.data_out = value_at[idx];
               r.slot = SLOT_BITS'(idx);
            end
         end else if (cmd == CMD_DELETE) begin
            if (!locate(ent, idx)) begin
               r.status = ST_ABSENT;
            end else begin
               last = fill - 1;
               if (idx != last) begin
                  moved = owner_at[last];
                  value_at[idx] = value_at[last];
                  owner_at[idx] = moved;
                  if (moved < ENTITY_SLOTS) link_of[moved] = idx + 1;
               end
               link_of[ent] = 0;
               fill = last;
               r.status = ST_OK;
               r.slot = SLOT_BITS'(idx);
            end
         end else begin
            if (locate(ent, idx)) begin
               r.status = ST_OK;
               r.data_out = value_at[idx];
               r.slot = SLOT_BITS'(idx);
            end else begin
               r.status = ST_ABSENT;
            end
         end
         r.entry_count = COUNT_BITS'(fill);
         if (fill > peak_fill) peak_fill = fill;
         awaited_replies.push_back(r);
      endfunction

      task report_mismatch(input string what, input logic [63:0] got, input logic [63:0] want);
         $display("tb: response %0d %s mismatch: got %0h, expected %0h", replies, what, got, want);
         failures++;
      endtask

      task check_reply(input rsp_type got);
         rsp_type want;
         replies++;
         if (awaited_replies.size() == 0) begin
            report_mismatch("unexpected transaction", 64'(got), 64'd0);
            return;
         end
         want = awaited_replies.pop_front();
         status_seen[got.status]++;
         if (got.status !== want.status)
            report_mismatch("status", 64'(got.status), 64'(want.status));
         if (got.data_out !== want.data_out)
            report_mismatch("data_out", 64'(got.data_out), 64'(want.data_out));
         if (got.slot !== want.slot)
            report_mismatch("slot", 64'(got.slot), 64'(want.slot));
         if (got.entry_count !== want.entry_count)
            report_mismatch("entry_count", 64'(got.entry_count), 64'(want.entry_count));
      endtask
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [47:0] req_tdata = '0;   // entity[15:0], data_in[47:16]
   logic [2:0]  req_tuser = '0;   // command[1:0], has_data[2]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [55:0] rsp_tdata;        // data_out[31:0], slot[41:32], entry_count[52:42]
   logic [1:0]  rsp_tuser;        // status[1:0]

   int unsigned send_idle_pct = 31;
   int unsigned rsp_idle_pct = 80;
   int unsigned cycle_count = 0;

   sparse_pool_model pool;

   sparse_set_component_pool_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #4 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= rsp_idle_pct);
   end

   always @(posedge clock) begin
      rsp_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.status = rsp_tuser;
         got.data_out = rsp_tdata[31:0];
         got.slot = rsp_tdata[41:32];
         got.entry_count = rsp_tdata[52:42];
         pool.check_reply(got);
      end
   end

   // call at a falling edge; returns at the falling edge after the transaction
   task automatic send_request(input logic [1:0] cmd, input logic [ENTITY_BITS-1:0] ent,
                               input logic [DATA_WIDTH-1:0] din, input bit hd);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {din, ent};
      req_tuser <= {hd, cmd};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pool.apply_request(cmd, ent, din, hd);
      @(negedge clock);
   endtask

   function automatic logic [ENTITY_BITS-1:0] pick_entity(input int unsigned window);
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 70) return ENTITY_BITS'($urandom_range(window - 1));
      if (roll < 82) return ENTITY_BITS'($urandom_range(ENTITY_SLOTS - 1));
      if (roll < 92) return ENTITY_BITS'($urandom_range(65535, ENTITY_SLOTS));
      case ($urandom_range(3))
         0: return '0;
         1: return ENTITY_BITS'(ENTITY_SLOTS - 1);
         2: return ENTITY_BITS'(ENTITY_SLOTS);
         default: return '1;
      endcase
   endfunction

   function automatic logic [DATA_WIDTH-1:0] pick_data();
      int unsigned roll;
      roll = $urandom_range(9);
      if (roll == 0) return '0;
      if (roll == 1) return '1;
      return DATA_WIDTH'($urandom());
   endfunction

   task automatic random_request(input int unsigned window);
      int unsigned roll;
      logic [1:0] cmd;
      roll = $urandom_range(99);
      if (roll < 30) cmd = CMD_LOOKUP;
      else if (roll < 70) cmd = CMD_INSERT;
      else if (roll < 95) cmd = CMD_DELETE;
      else cmd = CMD_UNUSED;
      send_request(cmd, pick_entity(window), pick_data(), 1'($urandom_range(1)));
   endtask

   initial begin
      int unsigned sweep_order [ENTITY_SLOTS];
      int unsigned j;
      int unsigned tmp;
      pool = new();
      repeat (12) @(negedge clock);
      reset <= 1'b0;

      send_request(CMD_LOOKUP, 16'd0, 32'h0000_0000, 1'b0);
      send_request(CMD_DELETE, 16'd0, 32'h0000_0000, 1'b1);
      send_request(CMD_INSERT, 16'd0, 32'hFFFF_FFFF, 1'b1);
      send_request(CMD_INSERT, 16'd1023, 32'hDEAD_BEEF, 1'b0);
      send_request(CMD_INSERT, 16'd1024, 32'h0F0F_0F0F, 1'b1);
      send_request(CMD_INSERT, 16'hFFFF, 32'h5555_5555, 1'b1);
      send_request(CMD_LOOKUP, 16'hFFFF, 32'hAAAA_AAAA, 1'b1);
      send_request(CMD_DELETE, 16'hFFFF, 32'h0000_0000, 1'b0);
      send_request(CMD_UNUSED, 16'd0, 32'h0000_0000, 1'b0);
      send_request(CMD_INSERT, 16'd0, 32'h0000_1234, 1'b0);
      send_request(CMD_INSERT, 16'd0, 32'h0000_0000, 1'b1);
      send_request(CMD_INSERT, 16'd5, 32'hAAAA_5555, 1'b1);
      send_request(CMD_LOOKUP, 16'd1023, 32'h0000_0000, 1'b0);
      send_request(CMD_DELETE, 16'd0, 32'h0000_0000, 1'b0);
      send_request(CMD_LOOKUP, 16'd5, 32'h0000_0000, 1'b0);
      send_request(CMD_LOOKUP, 16'd0, 32'h0000_0000, 1'b0);
      send_request(CMD_DELETE, 16'd1023, 32'h0000_0000, 1'b0);
      send_request(CMD_DELETE, 16'd1023, 32'h0000_0000, 1'b0);
      send_request(CMD_INSERT, 16'd1023, 32'h8000_0001, 1'b1);
      send_request(CMD_DELETE, 16'd5, 32'h0000_0000, 1'b0);
      send_request(CMD_DELETE, 16'd1023, 32'h0000_0000, 1'b0);
      send_request(CMD_LOOKUP, 16'd1023, 32'h0000_0000, 1'b0);

      // churn a small id window to exercise swap-remove
      repeat (130) random_request(48);

      // fill the pool completely in shuffled order
      send_idle_pct = 80;
      rsp_idle_pct = 31;
      for (int i = 0; i < ENTITY_SLOTS; i++) sweep_order[i] = i;
      for (int i = ENTITY_SLOTS - 1; i > 0; i--) begin
         j = $urandom_range(i);
         tmp = sweep_order[i];
         sweep_order[i] = sweep_order[j];
         sweep_order[j] = tmp;
      end
      for (int i = 0; i < ENTITY_SLOTS; i++) begin
         send_request(CMD_INSERT, ENTITY_BITS'(sweep_order[i]), pick_data(),
                      1'($urandom_range(1)));
         if ($urandom_range(7) == 0)
            send_request($urandom_range(1) ? CMD_LOOKUP : CMD_UNUSED, pick_entity(ENTITY_SLOTS),
                         pick_data(), 1'($urandom_range(1)));
      end

      send_idle_pct = 0;
      rsp_idle_pct = 0;
      repeat (4) send_request(CMD_INSERT, ENTITY_BITS'($urandom_range(65535, ENTITY_SLOTS)),
                              pick_data(), 1'b1);
      send_request(CMD_INSERT, ENTITY_BITS'($urandom_range(ENTITY_SLOTS - 1)), pick_data(), 1'b1);
      repeat (150) random_request(ENTITY_SLOTS);
      req_tvalid <= 1'b0;

      while (pool.awaited_replies.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("tb: %0d requests, %0d responses, peak fill %0d of %0d",
               pool.requests, pool.replies, pool.peak_fill, POOL_DEPTH);
      $display("tb: statuses seen ok %0d, absent %0d, full %0d, out of range %0d",
               pool.status_seen[ST_OK], pool.status_seen[ST_ABSENT],
               pool.status_seen[ST_FULL], pool.status_seen[ST_RANGE]);
      if (pool.failures == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+design
design/sspool_pkg.sv
design/sspool_ram.sv
design/sspool_seq.sv
design/sparse_set_component_pool_unit.sv
bench/sparse_set_component_pool_unit_tb.sv
